FILE: rtl/qtt_pkg.sv
package qtt_pkg;

   // Default sizes handed to the top level parameters.
   localparam int POS_BITS_DEF     = 16;
   localparam int NUM_KEYWORDS_DEF = 13;

   // Keyword table.
   localparam int KW_TABLE_SIZE = 13;
   localparam int KW_IDX_BITS   = 4;

   // Each keyword is left aligned in eight bytes, zero padded.
   localparam logic [63:0] KW_TEXT [KW_TABLE_SIZE] = '{
      {"TABLE",   24'h0},
      {"NEW",     40'h0},
      {"UPDATE",  16'h0},
      {"QUERY",   24'h0},
      {"DELETE",  16'h0},
      {"PRIMARY",  8'h0},
      {"KEY",     40'h0},
      {"CHAINS",  16'h0},
      {"COUNT",   24'h0},
      {"RANGE",   24'h0},
      {"IN",      48'h0},
      {"HELP",    32'h0},
      {"BULK",    32'h0}
   };
   localparam logic [2:0] KW_LEN [KW_TABLE_SIZE] = '{
      3'd5, 3'd3, 3'd6, 3'd5, 3'd6, 3'd7, 3'd3, 3'd6, 3'd5, 3'd5, 3'd2, 3'd4, 3'd4
   };

   // Scanner modes.
   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_STRING = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_WORD   = 3'd3;
   localparam logic [2:0] MODE_DROP   = 3'd4;

   // Token kinds.
   localparam logic [3:0] TOK_LPAREN  = 4'd0;
   localparam logic [3:0] TOK_RPAREN  = 4'd1;
   localparam logic [3:0] TOK_COMMA   = 4'd2;
   localparam logic [3:0] TOK_STRING  = 4'd3;
   localparam logic [3:0] TOK_NUMBER  = 4'd4;
   localparam logic [3:0] TOK_KEYWORD = 4'd5;
   localparam logic [3:0] TOK_IDENT   = 4'd6;
   localparam logic [3:0] TOK_END     = 4'd7;
   localparam logic [3:0] TOK_BAD     = 4'd8;
   localparam logic [3:0] TOK_UNTERM  = 4'd9;

   // Result queue.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_SLOTS = 3;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] char_byte;
      logic       end_of_statement;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [3:0]  keyword_index;
      logic [7:0]  bad_byte;
      logic        last_of_run;
   } rsp_type;

   // Up to three result beats produced by one input item, in order.
   typedef struct packed {
      logic [1:0]                count;
      rsp_type [RSP_SLOTS-1:0]   beat;
   } rsp_push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
   endfunction

   function automatic logic [7:0] kw_char(input logic [KW_IDX_BITS-1:0] k,
                                          input logic [2:0] i);
      logic [63:0] w;
      w = KW_TEXT[k] << (8 * i);
      return w[63:56];
   endfunction

endpackage

FILE: rtl/qtt_kw_narrow.sv
module qtt_kw_narrow #(
   parameter int POS_BITS     = qtt_pkg::POS_BITS_DEF,
   parameter int NUM_KEYWORDS = qtt_pkg::NUM_KEYWORDS_DEF
) (
   input  logic [NUM_KEYWORDS-1:0] cand,
   input  logic [POS_BITS-1:0]     len,
   input  logic [7:0]              char_byte,
   output logic [NUM_KEYWORDS-1:0] narrowed
);
   import qtt_pkg::*;

   localparam int KW_USED = (NUM_KEYWORDS < KW_TABLE_SIZE) ? NUM_KEYWORDS : KW_TABLE_SIZE;

   // A candidate survives only if its keyword has this letter at this place.
   always_comb begin
      logic [7:0] up;
      up = to_upper(char_byte);
      narrowed = cand;
      for (int k = 0; k < KW_USED; k++) begin
         if (!(len < POS_BITS'(KW_LEN[k]) &&
               kw_char(KW_IDX_BITS'(k), len[2:0]) == up)) begin
            narrowed[k] = 1'b0;
         end
      end
   end

endmodule

FILE: rtl/qtt_kw_find.sv
module qtt_kw_find #(
   parameter int POS_BITS     = qtt_pkg::POS_BITS_DEF,
   parameter int NUM_KEYWORDS = qtt_pkg::NUM_KEYWORDS_DEF
) (
   input  logic [NUM_KEYWORDS-1:0]         cand,
   input  logic [POS_BITS-1:0]             len,
   output logic                            hit,
   output logic [qtt_pkg::KW_IDX_BITS-1:0] index
);
   import qtt_pkg::*;

   localparam int KW_USED = (NUM_KEYWORDS < KW_TABLE_SIZE) ? NUM_KEYWORDS : KW_TABLE_SIZE;

   // Lowest surviving candidate whose length equals the word length wins.
   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int k = KW_USED - 1; k >= 0; k--) begin
         if (cand[k] && len == POS_BITS'(KW_LEN[k])) begin
            hit   = 1'b1;
            index = KW_IDX_BITS'(k);
         end
      end
   end

endmodule

FILE: rtl/qtt_scan.sv
module qtt_scan #(
   parameter int POS_BITS     = qtt_pkg::POS_BITS_DEF,
   parameter int NUM_KEYWORDS = qtt_pkg::NUM_KEYWORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  qtt_pkg::req_type      step_data,
   output qtt_pkg::rsp_push_type push
);
   import qtt_pkg::*;

   logic [2:0]              mode_ff, mode_in, mode_mid;
   logic [POS_BITS-1:0]     pos_ff, pos_in, pos_mid;
   logic [POS_BITS-1:0]     start_ff, start_in, start_mid;
   logic [POS_BITS-1:0]     len_ff, len_in, len_mid;
   logic [NUM_KEYWORDS-1:0] cand_ff, cand_in, cand_mid;

   logic [NUM_KEYWORDS-1:0] nar_cand_src, nar_out;
   logic [POS_BITS-1:0]     nar_len_src;
   logic                    old_hit, mid_hit;
   logic [KW_IDX_BITS-1:0]  old_idx, mid_idx;

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      return (v == '1) ? v : (v + POS_BITS'(1));
   endfunction

   function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic rsp_type mk(input logic [3:0] kind, input logic [POS_BITS-1:0] st,
                                  input logic [POS_BITS-1:0] ln,
                                  input logic [KW_IDX_BITS-1:0] kw, input logic [7:0] bad);
      rsp_type r;
      r.token_kind    = kind;
      r.token_start   = to16(st);
      r.token_length  = to16(ln);
      r.keyword_index = kw;
      r.bad_byte      = bad;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   // Narrowing either continues the current word or starts a fresh one.
   assign nar_cand_src = (mode_ff == MODE_WORD) ? cand_ff : '1;
   assign nar_len_src  = (mode_ff == MODE_WORD) ? len_ff : '0;

   qtt_kw_narrow #(.POS_BITS(POS_BITS), .NUM_KEYWORDS(NUM_KEYWORDS)) u_narrow (
      .cand      (nar_cand_src),
      .len       (nar_len_src),
      .char_byte (step_data.char_byte),
      .narrowed  (nar_out)
   );

   qtt_kw_find #(.POS_BITS(POS_BITS), .NUM_KEYWORDS(NUM_KEYWORDS)) u_find_old (
      .cand  (cand_ff),
      .len   (len_ff),
      .hit   (old_hit),
      .index (old_idx)
   );

   qtt_kw_find #(.POS_BITS(POS_BITS), .NUM_KEYWORDS(NUM_KEYWORDS)) u_find_mid (
      .cand  (cand_mid),
      .len   (len_mid),
      .hit   (mid_hit),
      .index (mid_idx)
   );

   always_comb begin
      logic [7:0]              c;
      logic                    do_idle;
      logic [3:0]              slot_v;
      rsp_type                 slot [4];
      rsp_type [RSP_SLOTS-1:0] beats;
      logic [2:0]              n;

      c         = step_data.char_byte;
      do_idle   = 1'b0;
      slot_v    = '0;
      for (int i = 0; i < 4; i++) begin
         slot[i] = '0;
      end
      mode_mid  = mode_ff;
      pos_mid   = pos_ff;
      start_mid = start_ff;
      len_mid   = len_ff;
      cand_mid  = cand_ff;

      // Slot 0: token closed by this byte. Slot 1: punctuation or bad byte.
      if (step_data.byte_valid) begin
         unique case (mode_ff)
            MODE_STRING: begin
               if (c == "'") begin
                  slot_v[0] = 1'b1;
                  slot[0]   = mk(TOK_STRING, start_ff, len_ff, '0, 8'd0);
                  mode_mid  = MODE_IDLE;
               end else begin
                  len_mid = sat_inc(len_ff);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c)) begin
                  len_mid = sat_inc(len_ff);
               end else begin
                  slot_v[0] = 1'b1;
                  slot[0]   = mk(TOK_NUMBER, start_ff, len_ff, '0, 8'd0);
                  do_idle   = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(c) || is_digit(c) || c == "_") begin
                  cand_mid = nar_out;
                  len_mid  = sat_inc(len_ff);
               end else begin
                  slot_v[0] = 1'b1;
                  slot[0]   = mk(old_hit ? TOK_KEYWORD : TOK_IDENT, start_ff, len_ff,
                                 old_hit ? old_idx : '0, 8'd0);
                  do_idle   = 1'b1;
               end
            end
            MODE_DROP: begin
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         if (do_idle) begin
            mode_mid = MODE_IDLE;
            if (is_space(c)) begin
            end else if (c == "(") begin
               slot_v[1] = 1'b1;
               slot[1]   = mk(TOK_LPAREN, pos_ff, POS_BITS'(1), '0, 8'd0);
            end else if (c == ")") begin
               slot_v[1] = 1'b1;
               slot[1]   = mk(TOK_RPAREN, pos_ff, POS_BITS'(1), '0, 8'd0);
            end else if (c == ",") begin
               slot_v[1] = 1'b1;
               slot[1]   = mk(TOK_COMMA, pos_ff, POS_BITS'(1), '0, 8'd0);
            end else if (c == "'") begin
               mode_mid  = MODE_STRING;
               start_mid = sat_inc(pos_ff);
               len_mid   = '0;
            end else if (is_digit(c)) begin
               mode_mid  = MODE_NUMBER;
               start_mid = pos_ff;
               len_mid   = POS_BITS'(1);
            end else if (is_alpha(c) || c == "_") begin
               mode_mid  = MODE_WORD;
               start_mid = pos_ff;
               len_mid   = POS_BITS'(1);
               cand_mid  = nar_out;
            end else begin
               slot_v[1] = 1'b1;
               slot[1]   = mk(TOK_BAD, pos_ff, POS_BITS'(1), '0, c);
               mode_mid  = MODE_DROP;
            end
         end
         pos_mid = sat_inc(pos_ff);
      end

      // Slot 2: pending token closed by the statement end. Slot 3: end token.
      if (step_data.end_of_statement) begin
         if (mode_mid == MODE_STRING) begin
            slot_v[2] = 1'b1;
            slot[2]   = mk(TOK_UNTERM, start_mid, len_mid, '0, 8'd0);
         end else if (mode_mid == MODE_NUMBER) begin
            slot_v[2] = 1'b1;
            slot[2]   = mk(TOK_NUMBER, start_mid, len_mid, '0, 8'd0);
         end else if (mode_mid == MODE_WORD) begin
            slot_v[2] = 1'b1;
            slot[2]   = mk(mid_hit ? TOK_KEYWORD : TOK_IDENT, start_mid, len_mid,
                           mid_hit ? mid_idx : '0, 8'd0);
         end
         slot_v[3] = 1'b1;
         slot[3]   = mk(TOK_END, pos_mid, '0, '0, 8'd0);
      end

      // Pack the live slots in order; anything past the third is dropped.
      n     = 3'd0;
      beats = '0;
      for (int i = 0; i < 4; i++) begin
         if (slot_v[i] && n < 3'(RSP_SLOTS)) begin
            beats[n[1:0]] = slot[i];
            n = n + 3'd1;
         end
      end
      if (n != 3'd0) begin
         beats[n[1:0] - 2'd1].last_of_run = 1'b1;
      end

      push.count = step_en ? n[1:0] : 2'd0;
      push.beat  = beats;

      if (step_data.end_of_statement) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         cand_in  = '1;
      end else begin
         mode_in  = mode_mid;
         pos_in   = pos_mid;
         start_in = start_mid;
         len_in   = len_mid;
         cand_in  = cand_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         cand_ff  <= '1;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         cand_ff  <= cand_in;
      end
   end

endmodule

FILE: rtl/qtt_rsp_queue.sv
module qtt_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  qtt_pkg::rsp_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output qtt_pkg::rsp_type      rsp_data
);
   import qtt_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_type          mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   // Room for a full burst of results from one item.
   assign room      = (count_ff <= CNT_W'(RSP_DEPTH - RSP_SLOTS));

   assign wptr_in  = wptr_ff + PTR_W'(push.count);
   assign rptr_in  = rptr_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_SLOTS; i++) begin
         if (i < int'(push.count)) begin
            mem_ff[wptr_ff + PTR_W'(i)] <= push.beat[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/query_text_tokenizer_core.sv
// A byte accepted into the input stage is scanned once the result queue has room, and
// its results go into the queue, whose head drives the result beat. One input beat is
// taken per cycle while the queue has room; an item can yield up to three result beats,
// and the eight-entry result queue takes in a burst while draining one beat per cycle
// when the consumer is ready. Reset (synchronous, active high) empties the input stage
// and the result queue and returns the scanner to the start of a fresh statement.
module query_text_tokenizer_core #(
   parameter int POS_BITS     = qtt_pkg::POS_BITS_DEF,
   parameter int NUM_KEYWORDS = qtt_pkg::NUM_KEYWORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qtt_pkg::rsp_type rsp_data
);
   import qtt_pkg::*;

   // The input stage holds one beat. It is scanned as soon as the result queue
   // has room for the worst case of three results, and it refills in the same
   // cycle, so a steady byte stream flows without bubbles.
   logic         stg_valid_ff, stg_valid_in;
   req_type      stg_data_ff;
   logic         advance;
   logic         room;
   rsp_push_type push;

   assign advance      = stg_valid_ff && room;
   assign req_ready    = !stg_valid_ff || advance;
   assign stg_valid_in = (req_valid && req_ready) || (stg_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   // Payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_data_ff <= req_data;
      end
   end

   // The scanner keeps the statement state and turns one byte into its results.
   qtt_scan #(.POS_BITS(POS_BITS), .NUM_KEYWORDS(NUM_KEYWORDS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_data (stg_data_ff),
      .push      (push)
   );

   // The result queue decouples the consumer; its head drives the result beat.
   qtt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The queue is empty right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat offered right after reset");

   // A statement end always produces at least one result.
   assert property (@(posedge clock) disable iff (reset)
      (advance && stg_data_ff.end_of_statement) |-> (push.count != 2'd0))
      else $error("statement end produced no result");

   // In a full burst only the final beat is marked as last of the run.
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd3) |->
         (push.beat[2].last_of_run && !push.beat[1].last_of_run &&
          !push.beat[0].last_of_run))
      else $error("last-of-run marking wrong in a three-result burst");

endmodule
